// File: rtl/udsc_pkg.sv
package udsc_pkg;

  typedef enum logic [1:0] {
    MODE_WAIT  = 2'd0,
    MODE_AVG   = 2'd1,
    MODE_WATCH = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ECHO   = 2'd1,
    CMD_SERIAL = 2'd2,
    CMD_DOOR   = 2'd3
  } cmd_t;

  // register indexes on the config port
  localparam logic [2:0] REG_DOOR_LEN  = 3'd0;
  localparam logic [2:0] REG_VALID_MIN = 3'd1;
  localparam logic [2:0] REG_VALID_MAX = 3'd2;
  localparam logic [2:0] REG_WARN_MIN  = 3'd3;
  localparam logic [2:0] REG_WARN_MAX  = 3'd4;

  localparam logic [7:0]  DOOR_LEN_RST  = 8'd30;
  localparam logic [15:0] VALID_MIN_RST = 16'd295;
  localparam logic [15:0] VALID_MAX_RST = 16'd23529;
  localparam logic [15:0] WARN_MIN_RST  = 16'd59;
  localparam logic [15:0] WARN_MAX_RST  = 16'd882;

  // serial command characters
  localparam logic [7:0] CH_SW_OFF     = 8'h30;
  localparam logic [7:0] CH_SW_ON      = 8'h31;
  localparam logic [7:0] CH_PERSON_OUT = 8'h35;
  localparam logic [7:0] CH_PERSON_IN  = 8'h36;

  localparam logic [17:0] SUM_MAX    = 18'h3ffff;
  localparam logic [6:0]  SERVO_BASE = 7'd50;
  localparam logic [6:0]  SERVO_FULL = 7'd100;

  localparam int TAN_STEPS = 12;
  localparam int KMUL_W    = 30;  // sample_count * 1000 * tan, count up to 15
  localparam int THR_W     = KMUL_W + 8;
  localparam int BASE_W    = 22;  // door * count * 1000

  // tan(3.6 * j deg), j = 1..12, in 16.16
  localparam logic [11:0][15:0] TAN_Q16 = {
    16'd61542, 16'd54216, 16'd47615, 16'd41590, 16'd36029, 16'd30839,
    16'd25948, 16'd21294, 16'd16827, 16'd12502, 16'd8279,  16'd4123
  };

  typedef struct packed {
    logic [15:0] valid_min;
    logic [15:0] valid_max;
    logic [15:0] warn_min;
    logic [15:0] warn_max;
  } win_cfg_t;

  typedef struct packed {
    logic                            door_zero;
    logic [BASE_W-1:0]               base;
    logic [TAN_STEPS-1:0][THR_W-1:0] thr;
  } servo_cfg_t;

  typedef struct packed {
    logic        fire;
    logic        sv;
    logic [17:0] sum;
    logic        lv;
    logic        lo;
    logic        rej;
    mode_t       mode;
  } mid_t;

  typedef struct packed {
    mode_t mode;
    logic  sw;
    logic  person;
    logic  door;
  } mstate_t;

  function automatic logic [TAN_STEPS-1:0][KMUL_W-1:0] scaled_tan(input int n);
    logic [TAN_STEPS-1:0][KMUL_W-1:0] r;
    for (int j = 0; j < TAN_STEPS; j++) begin
      r[j] = KMUL_W'(longint'(n) * 64'd1000 * longint'(TAN_Q16[j]));
    end
    return r;
  endfunction

  function automatic mstate_t mode_pass(input mstate_t s);
    mstate_t r;
    r = s;
    unique case (s.mode)
      MODE_AVG: begin
        if (!s.sw) begin
          r.mode   = MODE_WAIT;
          r.person = 1'b0;
        end
      end
      MODE_WATCH: begin
        if (!s.sw) r.mode = MODE_WAIT;
      end
      default: begin
        if (s.sw || s.person) r.mode = MODE_AVG;
        if (s.door) begin
          r.door = 1'b0;
          r.mode = MODE_WATCH;
        end
      end
    endcase
    return r;
  endfunction

  // six passes always reach the fixed point
  function automatic mstate_t mode_settle(input mstate_t s);
    mstate_t r;
    r = s;
    for (int p = 0; p < 6; p++) begin
      r = mode_pass(r);
    end
    return r;
  endfunction

endpackage

// File: rtl/ultrasonic_door_servo_controller_top.sv
// Channel   Dir  Transfer                  Payload
// in_*      in   in_tvalid & in_tready     tuser: cmd; tdata: edge_time, serial_byte
// out_*     out  out_tvalid & out_tready   tdata: one result flag/value word per event
// cfg_*     in   cfg_valid & cfg_ready     cfg_index selects register, cfg_data value
//
// One event per cycle while out_tready is high; each event yields exactly one
// result, registered in the state update stage, then in the servo table stage.
// rst_n is synchronous, active low: mode wait, flags and echo phase clear,
// config registers return to their defaults.
// Stalls: out_tready low holds the output word; in_tready drops whenever the
// output word is held and out_tready is low. cfg_ready is always high.
module ultrasonic_door_servo_controller_top #(
  parameter int SAMPLE_COUNT = 10,   // 1..15 echo widths per average
  parameter int TIMER_BITS   = 16    // 8..32, echo timer wrap width
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,    // [1:0] cmd
  input  logic [23:0] in_tdata,    // [15:0] edge_time, [23:16] serial_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] fire_trigger, [1] servo_valid, [8:2] servo_compare, [9] led_valid,
  // [10] led_on, [11] sample_rejected, [13:12] mode_now, [15:14] zero
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import udsc_pkg::*;

  win_cfg_t   win_cfg;
  servo_cfg_t servo_cfg;
  mid_t       mid;
  logic       mid_valid;
  logic       mid_ready;
  logic       in_acc;
  cmd_t       cmd;

  assign in_tready = mid_ready;
  assign in_acc    = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);

  // config registers plus door-length thresholds precomputed at write
  udsc_cfg #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .win_cfg   (win_cfg),
    .servo_cfg (servo_cfg)
  );

  // mode, echo phase, averaging; registers the per-event result draft
  udsc_core #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .TIMER_BITS   (TIMER_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_acc      (in_acc),
    .cmd         (cmd),
    .edge_time   (in_tdata[15:0]),
    .serial_byte (in_tdata[23:16]),
    .win_cfg     (win_cfg),
    .mid_ready   (mid_ready),
    .mid_valid   (mid_valid),
    .mid         (mid)
  );

  // tan threshold compare and output register
  udsc_servo u_servo (
    .clk        (clk),
    .rst_n      (rst_n),
    .mid_valid  (mid_valid),
    .mid        (mid),
    .servo_cfg  (servo_cfg),
    .mid_ready  (mid_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: rtl/udsc_cfg.sv
module udsc_cfg #(
  parameter int SAMPLE_COUNT = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  output udsc_pkg::win_cfg_t     win_cfg,
  output udsc_pkg::servo_cfg_t   servo_cfg
);
  import udsc_pkg::*;

  localparam logic [TAN_STEPS-1:0][KMUL_W-1:0] KMUL = scaled_tan(SAMPLE_COUNT);
  localparam logic [13:0] BASE_MUL = 14'(SAMPLE_COUNT * 1000);

  win_cfg_t   win_r,   win_nxt;
  servo_cfg_t servo_r, servo_nxt, servo_rst;
  logic       wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // door-derived thresholds are worked out once, at the write; here for the reset value
  always_comb begin
    servo_rst.door_zero = (DOOR_LEN_RST == 8'd0);
    servo_rst.base      = BASE_W'(DOOR_LEN_RST) * BASE_W'(BASE_MUL);
    for (int j = 0; j < TAN_STEPS; j++) begin
      servo_rst.thr[j] = THR_W'(DOOR_LEN_RST) * THR_W'(KMUL[j]);
    end
  end

  always_comb begin
    win_nxt   = win_r;
    servo_nxt = servo_r;
    if (wr) begin
      unique case (cfg_index)
        REG_DOOR_LEN: begin
          servo_nxt.door_zero = (cfg_data[7:0] == 8'd0);
          servo_nxt.base      = BASE_W'(cfg_data[7:0]) * BASE_W'(BASE_MUL);
          for (int j = 0; j < TAN_STEPS; j++) begin
            servo_nxt.thr[j] = THR_W'(cfg_data[7:0]) * THR_W'(KMUL[j]);
          end
        end
        REG_VALID_MIN: win_nxt.valid_min = cfg_data;
        REG_VALID_MAX: win_nxt.valid_max = cfg_data;
        REG_WARN_MIN:  win_nxt.warn_min  = cfg_data;
        REG_WARN_MAX:  win_nxt.warn_max  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.valid_min <= VALID_MIN_RST;
      win_r.valid_max <= VALID_MAX_RST;
      win_r.warn_min  <= WARN_MIN_RST;
      win_r.warn_max  <= WARN_MAX_RST;
      servo_r         <= servo_rst;
    end else begin
      win_r   <= win_nxt;
      servo_r <= servo_nxt;
    end
  end

  assign win_cfg   = win_r;
  assign servo_cfg = servo_r;

endmodule

// File: rtl/udsc_core.sv
module udsc_core #(
  parameter int SAMPLE_COUNT = 10,
  parameter int TIMER_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_acc,
  input  udsc_pkg::cmd_t       cmd,
  input  logic [15:0]          edge_time,
  input  logic [7:0]           serial_byte,
  input  udsc_pkg::win_cfg_t   win_cfg,
  input  logic                 mid_ready,
  output logic                 mid_valid,
  output udsc_pkg::mid_t       mid
);
  import udsc_pkg::*;

  localparam int WW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam int SW = ((WW > 18) ? WW : 18) + 1;
  localparam logic [15:0] TMASK =
    (TIMER_BITS >= 16) ? 16'hffff : 16'((32'd1 << TIMER_BITS) - 32'd1);
  localparam logic [WW-1:0] TMAX = WW'((64'd1 << TIMER_BITS) - 64'd1);
  localparam logic [3:0] CNT_DONE = 4'(SAMPLE_COUNT);

  mstate_t     ms_r, ms_nxt, ms_pre;
  logic        phase_r, phase_nxt;
  logic [15:0] rise_r, rise_nxt;
  logic [17:0] sum_r, sum_nxt;
  logic [3:0]  cnt_r, cnt_nxt, cnt_inc;
  mid_t        mid_r, mid_nxt;
  logic        mid_v_r, mid_v_nxt;

  logic [15:0]   t_m;
  logic [WW-1:0] t_w, rise_w, w;
  logic [SW-1:0] sum_wide;
  logic [17:0]   sum_sat;
  logic          in_valid_win, in_warn_win;

  always_comb begin
    t_m    = edge_time & TMASK;
    t_w    = WW'(t_m);
    rise_w = WW'(rise_r);
    if (t_w > rise_w)      w = t_w - rise_w;
    else if (t_w < rise_w) w = TMAX - rise_w + t_w;
    else                   w = '0;
    in_valid_win = (w >= WW'(win_cfg.valid_min)) && (w <= WW'(win_cfg.valid_max));
    in_warn_win  = (w >= WW'(win_cfg.warn_min)) && (w <= WW'(win_cfg.warn_max));
    sum_wide     = SW'(sum_r) + SW'(w);
    sum_sat      = (sum_wide > SW'(SUM_MAX)) ? SUM_MAX : sum_wide[17:0];
    cnt_inc      = cnt_r + 4'd1;
  end

  always_comb begin
    ms_pre    = ms_r;
    phase_nxt = phase_r;
    rise_nxt  = rise_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    mid_nxt   = '0;
    ms_nxt    = ms_r;
    if (in_acc) begin
      unique case (cmd)
        CMD_TICK: mid_nxt.fire = (ms_r.mode != MODE_WAIT);
        CMD_ECHO: begin
          if (!phase_r) begin
            rise_nxt  = t_m;
            phase_nxt = 1'b1;
          end else begin
            phase_nxt = 1'b0;
            if (ms_r.mode == MODE_AVG) begin
              if (in_valid_win) begin
                sum_nxt = sum_sat;
                cnt_nxt = cnt_inc;
                if (cnt_inc >= CNT_DONE) begin
                  mid_nxt.sv   = 1'b1;
                  mid_nxt.sum  = sum_sat;
                  sum_nxt      = '0;
                  cnt_nxt      = '0;
                  ms_pre.mode  = MODE_WAIT;
                end
              end else begin
                mid_nxt.rej = 1'b1;
              end
            end else if (ms_r.mode == MODE_WATCH) begin
              mid_nxt.lv = 1'b1;
              mid_nxt.lo = in_warn_win;
            end
          end
        end
        CMD_SERIAL: begin
          if (serial_byte == CH_SW_OFF || serial_byte == CH_SW_ON) begin
            ms_pre.sw = (serial_byte == CH_SW_ON);
          end else if (serial_byte == CH_PERSON_OUT || serial_byte == CH_PERSON_IN) begin
            ms_pre.person = (serial_byte == CH_PERSON_IN);
          end
        end
        CMD_DOOR: ms_pre.door = 1'b1;
        default: ;
      endcase
      ms_nxt       = mode_settle(ms_pre);
      mid_nxt.mode = ms_nxt.mode;
    end
  end

  always_comb begin
    mid_v_nxt = mid_v_r;
    if (in_acc)         mid_v_nxt = 1'b1;
    else if (mid_ready) mid_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r    <= '{mode: MODE_WAIT, sw: 1'b0, person: 1'b0, door: 1'b0};
      phase_r <= 1'b0;
      rise_r  <= '0;
      sum_r   <= '0;
      cnt_r   <= '0;
      mid_v_r <= 1'b0;
    end else begin
      ms_r    <= ms_nxt;
      phase_r <= phase_nxt;
      rise_r  <= rise_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      mid_v_r <= mid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) mid_r <= mid_nxt;
  end

  assign mid_valid = mid_v_r;
  assign mid       = mid_r;

  // count wraps to zero as it reaches the sample total
  a_cnt_below: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_DONE)
    else $error("sample count reached its limit");

  a_sv_rej: assert property (@(posedge clk) disable iff (!rst_n)
    mid_v_r |-> !(mid_r.sv && mid_r.rej))
    else $error("servo update and reject in one result");

  a_led_watch: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_v_r && mid_r.lv) |-> (mid_r.mode == MODE_WATCH))
    else $error("LED update outside watch mode");

endmodule

// File: rtl/udsc_servo.sv
module udsc_servo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  mid_valid,
  input  udsc_pkg::mid_t        mid,
  input  udsc_pkg::servo_cfg_t  servo_cfg,
  output logic                  mid_ready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata
);
  import udsc_pkg::*;

  logic [22:0]          lhs;
  logic [THR_W:0]       lhs_q;
  logic [TAN_STEPS-1:0] ge;
  logic [2:0]           k_lo, k_hi;
  logic [3:0]           k;
  logic                 above;
  logic [6:0]           comp;
  logic [15:0]          data_nxt, data_r;
  logic                 v_r, v_nxt;
  logic                 take;

  // sum * 17 against door * count * 1000 * tan(j), compared in 16.16
  always_comb begin
    lhs   = {mid.sum, 4'b0} + 23'(mid.sum);
    lhs_q = {lhs, 16'b0};
    for (int j = 0; j < TAN_STEPS; j++) begin
      ge[j] = (lhs_q >= {1'b0, servo_cfg.thr[j]});
    end
    k_lo = '0;
    k_hi = '0;
    for (int j = 0; j < TAN_STEPS / 2; j++) begin
      k_lo = k_lo + 3'(ge[j]);
      k_hi = k_hi + 3'(ge[j + TAN_STEPS / 2]);
    end
    k     = 4'(k_lo) + 4'(k_hi);
    above = servo_cfg.door_zero || (23'(servo_cfg.base) < lhs);
    comp  = above ? SERVO_FULL : (SERVO_BASE + 7'(k));
    if (!mid.sv) comp = '0;
    data_nxt = {2'b00, mid.mode, mid.rej, mid.lo, mid.lv, comp, mid.sv, mid.fire};
  end

  assign mid_ready = !v_r || out_tready;
  assign take      = mid_valid && mid_ready;

  always_comb begin
    v_nxt = v_r;
    if (take)            v_nxt = 1'b1;
    else if (out_tready) v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else        v_r <= v_nxt;
  end

  always_ff @(posedge clk) begin
    if (take) data_r <= data_nxt;
  end

  assign out_tvalid = v_r;
  assign out_tdata  = data_r;

  a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && data_r[1]) |-> (data_r[8:2] >= SERVO_BASE && data_r[8:2] <= SERVO_FULL))
    else $error("servo compare out of range");

  a_comp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && !data_r[1]) |-> (data_r[8:2] == 7'd0))
    else $error("servo compare set without servo update");

  a_fire_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && data_r[0]) |-> (!data_r[1] && !data_r[9] && !data_r[11]))
    else $error("trigger shares a result with an echo outcome");

endmodule
